/* sv/pwd_pkg.sv */
// pwd_pkg: constants and types shared by the packet word descrambler.
// Used by pwd_core and packet_word_descrambler; depends on nothing.
`timescale 1ns / 1ps

package pwd_pkg;

    localparam int unsigned DEF_MAX_WORDS = 16384;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 15;
    localparam int unsigned INDEX_W = 14;

    localparam logic [WORD_W-1:0] KEY_MODE1_START = 64'h0000_0000_6593_65E7;
    localparam logic [WORD_W-1:0] SUB_MODE0       = 64'h0000_0000_6593_65E7;
    localparam logic [WORD_W-1:0] SUB_MODE1       = 64'h0000_0000_4224_37A9;

    localparam int unsigned ROT0_A = 14;  // mode 0: rotate right, then right
    localparam int unsigned ROT0_B = 29;
    localparam int unsigned ROT1_A = 7;   // mode 1: rotate right, then left
    localparam int unsigned ROT1_B = 25;

    typedef enum logic {
        MODE_ZONE    = 1'b0,
        MODE_PROFILE = 1'b1
    } t_mode;

    // key schedule state seen by one round
    typedef struct packed {
        t_mode             mode;
        logic [WORD_W-1:0] key;
    } t_key_state;

endpackage

/* sv/pwd_core.sv */
// pwd_core: one descramble round: add key, rotate, subtract, rotate, and the key update.
// Purely combinational; depends on pwd_pkg.
`timescale 1ns / 1ps

module pwd_core (
    input  pwd_pkg::t_key_state          i_state,
    input  logic [pwd_pkg::WORD_W-1:0]   i_word,
    output logic [pwd_pkg::WORD_W-1:0]   o_plain,
    output logic [pwd_pkg::WORD_W-1:0]   o_next_key
);

    logic [pwd_pkg::WORD_W-1:0] sum;
    logic [pwd_pkg::WORD_W-1:0] rot_a;
    logic [pwd_pkg::WORD_W-1:0] diff;
    logic [pwd_pkg::WORD_W-1:0] sub;

    always_comb begin
        sum = i_word + i_state.key;
        case (i_state.mode)
            pwd_pkg::MODE_PROFILE: begin
                sub     = pwd_pkg::SUB_MODE1;
                rot_a   = {sum[pwd_pkg::ROT1_A-1:0], sum[pwd_pkg::WORD_W-1:pwd_pkg::ROT1_A]};
                diff    = rot_a - sub;
                o_plain = {diff[pwd_pkg::WORD_W-pwd_pkg::ROT1_B-1:0],
                           diff[pwd_pkg::WORD_W-1:pwd_pkg::WORD_W-pwd_pkg::ROT1_B]};
            end
            default: begin
                sub     = pwd_pkg::SUB_MODE0;
                rot_a   = {sum[pwd_pkg::ROT0_A-1:0], sum[pwd_pkg::WORD_W-1:pwd_pkg::ROT0_A]};
                diff    = rot_a - sub;
                o_plain = {diff[pwd_pkg::ROT0_B-1:0], diff[pwd_pkg::WORD_W-1:pwd_pkg::ROT0_B]};
            end
        endcase
        // key follows the plaintext
        o_next_key = i_state.key + o_plain - sub;
    end

endmodule

/* sv/packet_word_descrambler.sv */
// packet_word_descrambler: top level; input register, one round, result register.
// Depends on pwd_pkg and pwd_core.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+------------------------------------------
//   in      | i_in_valid  | o_in_ready  | i_operation, i_data_word, i_word_count
//   out     | o_out_valid | i_out_ready | o_plain_word, o_dest_index, o_last_word
//
// One word per cycle sustained while the output takes results; each word goes through the
// input register, then the result register. The per-word path is the key add,
// constant subtract and key update adders in pwd_core. Reset clears the key, word
// position and mode. When the result register is held by the output, the input
// register still takes one more word, then the input stalls.
`timescale 1ns / 1ps

module packet_word_descrambler #(
    parameter int unsigned MAX_WORDS = pwd_pkg::DEF_MAX_WORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [pwd_pkg::WORD_W-1:0]    i_data_word,
    input  logic [pwd_pkg::COUNT_W-1:0]   i_word_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pwd_pkg::WORD_W-1:0]    o_plain_word,
    output logic [pwd_pkg::INDEX_W-1:0]   o_dest_index,
    output logic                          o_last_word
);

    localparam int unsigned POS_W   = $clog2(MAX_WORDS);
    localparam int unsigned MAXC_W  = $clog2(MAX_WORDS + 1);
    localparam int unsigned CNT_W   = (MAXC_W > pwd_pkg::COUNT_W) ? MAXC_W : pwd_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

    // input register
    logic                          r_in_vld;
    logic                          r_in_op;
    logic [pwd_pkg::WORD_W-1:0]    r_in_word;
    logic [pwd_pkg::COUNT_W-1:0]   r_in_cnt;

    // packet state
    logic [pwd_pkg::WORD_W-1:0]    r_key;
    logic [POS_W-1:0]              r_pos;
    pwd_pkg::t_mode                r_mode;

    // result register
    logic                          r_out_vld;
    logic [pwd_pkg::WORD_W-1:0]    r_out_word;
    logic [pwd_pkg::INDEX_W-1:0]   r_out_idx;
    logic                          r_out_last;

    logic                          move;
    logic                          first;
    pwd_pkg::t_key_state           cur_state;
    logic [pwd_pkg::WORD_W-1:0]    plain;
    logic [pwd_pkg::WORD_W-1:0]    next_key;
    logic [CNT_W-1:0]              count;
    logic [CNT_W-1:0]              half;
    logic [CNT_W-1:0]              pos_ext;
    logic [CNT_W-1:0]              dest;
    logic                          last;
    logic [POS_W-1:0]              n_pos;

    assign move       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || !r_out_vld || i_out_ready;

    always_comb begin
        first = (r_pos == '0);
        if (first) begin
            cur_state.mode = pwd_pkg::t_mode'(r_in_op);
            cur_state.key  = r_in_op ? pwd_pkg::KEY_MODE1_START : '0;
        end else begin
            cur_state.mode = r_mode;
            cur_state.key  = r_key;
        end

        // zero count means a one-word packet; saturate at the buffer depth
        count = CNT_W'(r_in_cnt);
        if (count == '0) begin
            count = CNT_W'(1);
        end
        if (count > MAX_CNT) begin
            count = MAX_CNT;
        end
        half    = count >> 1;
        pos_ext = CNT_W'(r_pos);

        // word 0 and word count/2 trade places
        dest = pos_ext;
        if (count >= CNT_W'(2)) begin
            if (pos_ext == '0) begin
                dest = half;
            end else if (pos_ext == half) begin
                dest = '0;
            end
        end

        last  = (pos_ext + CNT_W'(1)) >= count;
        n_pos = last ? '0 : r_pos + POS_W'(1);
    end

    pwd_core u_core (
        .i_state    (cur_state),
        .i_word     (r_in_word),
        .o_plain    (plain),
        .o_next_key (next_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_key     <= '0;
            r_pos     <= '0;
            r_mode    <= pwd_pkg::MODE_ZONE;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
                r_key     <= next_key;
                r_pos     <= n_pos;
                r_mode    <= cur_state.mode;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op   <= i_operation;
            r_in_word <= i_data_word;
            r_in_cnt  <= i_word_count;
        end
        if (move) begin
            r_out_word <= plain;
            r_out_idx  <= dest[pwd_pkg::INDEX_W-1:0];
            r_out_last <= last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_plain_word = r_out_word;
    assign o_dest_index = r_out_idx;
    assign o_last_word  = r_out_last;

endmodule

/* sv/pwd_checker.sv */
// pwd_checker: port-level assertions for packet_word_descrambler, bound to the top level.
// Depends on pwd_pkg for field widths.
`timescale 1ns / 1ps

module pwd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_operation,
    input logic [pwd_pkg::WORD_W-1:0]    i_data_word,
    input logic [pwd_pkg::COUNT_W-1:0]   i_word_count,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pwd_pkg::WORD_W-1:0]    o_plain_word,
    input logic [pwd_pkg::INDEX_W-1:0]   o_dest_index,
    input logic                          o_last_word
);

    // upstream holds a stalled transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_operation) && $stable(i_data_word) &&
            $stable(i_word_count))
        else $error("input payload changed while stalled");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_plain_word) && $stable(o_dest_index) &&
            $stable(o_last_word))
        else $error("result changed or dropped while stalled");

    // with the result register empty there is always room for a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind packet_word_descrambler pwd_checker u_pwd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_operation  (i_operation),
    .i_data_word  (i_data_word),
    .i_word_count (i_word_count),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_plain_word (o_plain_word),
    .o_dest_index (o_dest_index),
    .o_last_word  (o_last_word)
);

/* sim/packet_word_descrambler_test.sv */
// packet_word_descrambler_test: self-checking bench for packet_word_descrambler.
// Predicts each descrambled word, index and last flag per input transfer and checks results
// in order. Depends on pwd_pkg and packet_word_descrambler.
`timescale 1ns / 1ps

module packet_word_descrambler_test;

    import pwd_pkg::*;

    localparam int unsigned MAX_WORDS = DEF_MAX_WORDS;
    localparam int unsigned PHASE_WORDS = 330;

    typedef struct {
        t_mode                op;
        logic [WORD_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
    } t_scrambled_word;

    typedef struct {
        logic [WORD_W-1:0]    plain;
        logic [INDEX_W-1:0]   dest;
        logic                 last;
    } t_plain_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation = 1'b0;
    logic [WORD_W-1:0]     i_data_word = '0;
    logic [COUNT_W-1:0]    i_word_count = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [WORD_W-1:0]     o_plain_word;
    logic [INDEX_W-1:0]    o_dest_index;
    logic                  o_last_word;

    t_scrambled_word       scrambled_words[$];
    t_plain_result         expected_words[$];
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           mismatch_count = 0;

    // predictor state
    logic [WORD_W-1:0]     descr_key = '0;
    int unsigned           descr_pos = 0;
    t_mode                 descr_mode = MODE_ZONE;

    packet_word_descrambler #(
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_word (i_data_word),
        .i_word_count(i_word_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_plain_word(o_plain_word),
        .o_dest_index(o_dest_index),
        .o_last_word (o_last_word)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_plain_result descramble_word(input t_mode op,
                                                      input logic [WORD_W-1:0] data,
                                                      input logic [COUNT_W-1:0] count);
        int unsigned       n;
        int unsigned       half;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] sub;
        t_plain_result     r;
        n = count;
        if (n == 0) n = 1;
        if (n > MAX_WORDS) n = MAX_WORDS;
        if (descr_pos == 0) begin
            descr_mode = op;
            descr_key = (op == MODE_PROFILE) ? KEY_MODE1_START : '0;
        end
        w = data + descr_key;
        if (descr_mode == MODE_PROFILE) begin
            sub = SUB_MODE1;
            w = (w >> ROT1_A) | (w << (WORD_W - ROT1_A));
            w = w - sub;
            w = (w << ROT1_B) | (w >> (WORD_W - ROT1_B));
        end else begin
            sub = SUB_MODE0;
            w = (w >> ROT0_A) | (w << (WORD_W - ROT0_A));
            w = w - sub;
            w = (w >> ROT0_B) | (w << (WORD_W - ROT0_B));
        end
        descr_key = descr_key + w - sub;
        r.plain = w;
        r.dest = descr_pos[INDEX_W-1:0];
        if (n >= 2) begin
            half = n / 2;
            if (descr_pos == 0) r.dest = half[INDEX_W-1:0];
            else if (descr_pos == half) r.dest = '0;
        end
        r.last = (descr_pos + 1 >= n);
        descr_pos = r.last ? 0 : descr_pos + 1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic push_word(input t_mode op, input logic [WORD_W-1:0] data,
                             input logic [COUNT_W-1:0] count);
        t_scrambled_word sw;
        sw.op = op;
        sw.data = data;
        sw.count = count;
        scrambled_words.push_back(sw);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    // Well-formed packets mostly; some carry a count that changes partway through.
    task automatic push_packet();
        int unsigned n;
        int unsigned pick;
        int unsigned bad_at;
        bit          broken;
        t_mode       mode;
        logic [COUNT_W-1:0] cnt;
        mode = t_mode'($urandom_range(1));
        pick = $urandom_range(99);
        broken = 1'b0;
        if (pick < 60) n = $urandom_range(8, 1);
        else if (pick < 80) n = $urandom_range(40, 9);
        else if (pick < 85) n = 0;
        else begin
            n = $urandom_range(10, 2);
            broken = 1'b1;
        end
        bad_at = $urandom_range(n > 1 ? n - 1 : 0);
        for (int unsigned i = 0; i < (n == 0 ? 1 : n); i++) begin
            cnt = n[COUNT_W-1:0];
            if (broken && i == bad_at)
                cnt = ($urandom_range(1) != 0) ? COUNT_W'($urandom_range(32767))
                                                : COUNT_W'($urandom_range(6));
            push_word(i == 0 ? mode : t_mode'($urandom_range(1)), random_word(), cnt);
        end
    endtask

    // Driver: present queued words, predict each one on its transfer.
    always @(posedge i_clk) begin : drive
        t_scrambled_word sw;
        bit              held;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            held = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready)
                expected_words.push_back(descramble_word(t_mode'(i_operation),
                                                         i_data_word, i_word_count));
            if (!held) begin
                if (scrambled_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sw = scrambled_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= sw.op;
                    i_data_word <= sw.data;
                    i_word_count <= sw.count;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin : watch
        t_plain_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", o_plain_word));
            end else begin
                want = expected_words.pop_front();
                if (o_plain_word !== want.plain)
                    report_mismatch($sformatf("plain_word %h, expected %h",
                                              o_plain_word, want.plain));
                if (o_dest_index !== want.dest)
                    report_mismatch($sformatf("dest_index %0d, expected %0d",
                                              o_dest_index, want.dest));
                if (o_last_word !== want.last)
                    report_mismatch($sformatf("last_word %b, expected %b",
                                              o_last_word, want.last));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 49 : 0;
            recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 9 : 0;
            if (phase == 0) begin
                push_word(MODE_ZONE, '0, 1);                    // one-word packet
                push_word(MODE_PROFILE, '1, 0);                 // zero count acts as one
                push_word(MODE_PROFILE, '1, 2);
                push_word(MODE_ZONE, '0, 2);                    // mode ignored mid-packet
                push_word(MODE_ZONE, 64'h8000_0000_0000_0000, 3);
                push_word(MODE_PROFILE, 64'h0000_0000_0000_0001, 3);
                push_word(MODE_ZONE, 64'h0123_4567_89AB_CDEF, 3);
                push_word(MODE_PROFILE, random_word(), 15'h7FFF); // saturates
                push_word(MODE_ZONE, random_word(), 2);
                push_word(MODE_ZONE, random_word(), 15'd16385);
                push_word(MODE_PROFILE, random_word(), 2);
                push_word(MODE_ZONE, random_word(), 15'd16384);
                push_word(MODE_ZONE, random_word(), 1);         // count drops: ends packet
                push_word(MODE_ZONE, random_word(), 5);
                push_word(MODE_PROFILE, random_word(), 5);
                push_word(MODE_ZONE, random_word(), 3);         // count changes mid-packet
                for (int i = 0; i < 4; i++)
                    push_word(MODE_PROFILE, random_word(), 4);
                for (int i = 0; i < 5; i++)
                    push_word(MODE_ZONE, '1, 5);
            end
            while (scrambled_words.size() < PHASE_WORDS)
                push_packet();
            // hold off the next phase until everything has drained
            while (scrambled_words.size() != 0 || i_in_valid || expected_words.size() != 0)
                @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
sv/pwd_pkg.sv
sv/pwd_core.sv
sv/packet_word_descrambler.sv
sv/pwd_checker.sv
sim/packet_word_descrambler_test.sv
